/* design/rpm_pkg.sv */
// shared types and constants of the rms and peak level meter
package rpm_pkg;

	// sample, square, mean and root widths, root step count and count, word and output widths
	localparam int SAMPLE_W   = 24;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int MEAN_W     = 48;
	localparam int ROOT_W     = MEAN_W / 2;
	localparam int ROOT_STEPS = MEAN_W / 2;
	localparam int RREM_W     = ROOT_W + 2;
	localparam int COUNT_W    = 14;
	localparam int WORD_W     = 32;
	localparam int OUT_DATA_W = 64;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ADD,
		ST_DIV,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_PUBLISH
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic square;
		logic div_load;
		logic div_step;
		logic root_load;
		logic root_step;
		logic publish;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_last;
		logic root_last;
		logic out_busy;
	} sts_t;

endpackage

/* design/rms_peak_level_meter_top.sv */
// Order: a sample is taken in one cycle and squared in the next, so the input is not
// ready while a sample is squared; a chunk's last sample then goes through an add
// state, the bit-serial divider, the root load and the square root that brings in two
// radicand bits per step, and the publish state; the result is then valid, with input
// held off until then and longer while an earlier result is still stalled at the output.
// Reset (arst_n low) clears the sum, peak, count, overflow flag and output valid.
module rms_peak_level_meter_top #(
	parameter int CHUNK_MAX = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample_word[31:0]
	input  logic        s_axis_tlast,  // last_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [rpm_pkg::OUT_DATA_W-1:0] m_axis_tdata  // rms_level[23:0], peak_level[47:24],
	                                   // sample_count[61:48], count_overflow[62], zero[63]
);

	rpm_pkg::cmd_t                cmd;
	rpm_pkg::sts_t                sts;
	logic [rpm_pkg::ROOT_W-1:0]   rms_level;
	logic [rpm_pkg::SAMPLE_W-1:0] peak_level;
	logic [rpm_pkg::COUNT_W-1:0]  sample_count;
	logic                         count_overflow;

	// controller
	rpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	rpm_dpath #(
		.CHUNK_MAX (CHUNK_MAX)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_word    (s_axis_tdata),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.rms_level      (rms_level),
		.peak_level     (peak_level),
		.sample_count   (sample_count),
		.count_overflow (count_overflow)
	);

	// result packing
	assign m_axis_tdata = {1'b0, count_overflow, sample_count, peak_level, rms_level};

`ifndef SYNTH
	// a sample transaction is always followed by its squaring cycle
	a_square_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken in the cycle after a sample transaction");

	// the root of a mean square never exceeds full scale
	a_rms_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:0] <= 24'h800000)
		else $error("rms level above full scale");

	// the peak magnitude never exceeds full scale
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:24] <= 24'h800000)
		else $error("peak level above full scale");
`endif

endmodule

/* design/rpm_ctrl.sv */
// controller state machine of the rms and peak level meter
module rpm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  rpm_pkg::sts_t sts,
	output rpm_pkg::cmd_t cmd
);

	rpm_pkg::state_t state_q, state_d;
	logic            last_q;

	// state register and last flag of the held sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpm_pkg::ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				last_q <= in_last;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rpm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = rpm_pkg::ST_SQUARE;
				end
			end
			rpm_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = last_q ? rpm_pkg::ST_ADD : rpm_pkg::ST_IDLE;
			end
			rpm_pkg::ST_ADD: begin
				cmd.div_load = 1'b1;
				state_d      = rpm_pkg::ST_DIV;
			end
			rpm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = rpm_pkg::ST_ROOT_LOAD;
				end
			end
			rpm_pkg::ST_ROOT_LOAD: begin
				cmd.root_load = 1'b1;
				state_d       = rpm_pkg::ST_ROOT;
			end
			rpm_pkg::ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last) begin
					state_d = rpm_pkg::ST_PUBLISH;
				end
			end
			rpm_pkg::ST_PUBLISH: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = rpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/rpm_dpath.sv */
// datapath of the rms and peak level meter: accumulators, divider, root and output register
module rpm_dpath #(
	parameter int CHUNK_MAX = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rpm_pkg::WORD_W-1:0]    sample_word,
	input  rpm_pkg::cmd_t                 cmd,
	output rpm_pkg::sts_t                 sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rpm_pkg::ROOT_W-1:0]    rms_level,
	output logic [rpm_pkg::SAMPLE_W-1:0]  peak_level,
	output logic [rpm_pkg::COUNT_W-1:0]   sample_count,
	output logic                          count_overflow
);

	localparam int CNT_W  = $clog2(CHUNK_MAX + 1);
	localparam int SUM_W  = 2 * rpm_pkg::SAMPLE_W - 1 + $clog2(CHUNK_MAX);
	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CHUNK_MAX);

	logic [rpm_pkg::SAMPLE_W-1:0] top_sample;
	logic [rpm_pkg::SAMPLE_W-1:0] mag_q;
	logic [rpm_pkg::SQ_W-1:0]     sq_q;
	logic [SUM_W-1:0]             sum_q, sum_next;
	logic [rpm_pkg::SAMPLE_W-1:0] peak_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q, add_pend_q, out_valid_q;
	logic [STEP_W-1:0]            step_q;
	logic [CNT_W-1:0]             rem_q;
	logic [SUM_W-1:0]             quo_q;
	logic [CNT_W:0]               rem_shift;
	logic                         rem_ge;
	logic [rpm_pkg::MEAN_W-1:0]   rad_q;
	logic [rpm_pkg::ROOT_W-1:0]   root_q;
	logic [rpm_pkg::RREM_W-1:0]   rrem_q;
	logic [rpm_pkg::RREM_W+1:0]   trial, test_val;
	logic                         trial_ge;
	logic                         counted;

	// top sample field, count limit check and accumulator sum
	assign top_sample = sample_word[rpm_pkg::WORD_W-1 -: rpm_pkg::SAMPLE_W];
	assign counted    = count_q < CNT_LIMIT;
	assign sum_next   = sum_q + SUM_W'(sq_q);

	// divider step: shift in one dividend bit and subtract when it fits
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, count_q};

	// root step: bring in two radicand bits, test against 4*root+1
	assign trial    = {rrem_q, rad_q[rpm_pkg::MEAN_W-1 -: 2]};
	assign test_val = {2'b00, root_q, 2'b01};
	assign trial_ge = trial >= test_val;

	// accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			peak_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			add_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			add_pend_q <= 1'b0;
			if (add_pend_q) begin
				sum_q <= sum_next;
			end
			if (cmd.square) begin
				if (counted) begin
					add_pend_q <= 1'b1;
					count_q    <= count_q + CNT_W'(1);
					if (mag_q > peak_q) begin
						peak_q <= mag_q;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.publish) begin
				sum_q   <= '0;
				peak_q  <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample, square, divider, root and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_q <= top_sample[rpm_pkg::SAMPLE_W-1]
				? (~top_sample + rpm_pkg::SAMPLE_W'(1)) : top_sample;
		end
		if (cmd.square) begin
			sq_q <= rpm_pkg::SQ_W'(mag_q) * rpm_pkg::SQ_W'(mag_q);
		end
		if (cmd.div_load) begin
			quo_q  <= add_pend_q ? sum_next : sum_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? CNT_W'(rem_shift - {1'b0, count_q}) : rem_shift[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], rem_ge};
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.root_load) begin
			rad_q  <= quo_q[rpm_pkg::MEAN_W-1:0];
			root_q <= '0;
			rrem_q <= '0;
			step_q <= '0;
		end else if (cmd.root_step) begin
			rrem_q <= trial_ge ? rpm_pkg::RREM_W'(trial - test_val)
			                   : trial[rpm_pkg::RREM_W-1:0];
			root_q <= {root_q[rpm_pkg::ROOT_W-2:0], trial_ge};
			rad_q  <= {rad_q[rpm_pkg::MEAN_W-3:0], 2'b00};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.publish) begin
			rms_level      <= root_q;
			peak_level     <= peak_q;
			sample_count   <= rpm_pkg::COUNT_W'(count_q);
			count_overflow <= ovf_q;
		end
	end

	// status to the controller
	assign sts.div_last  = step_q == STEP_W'(SUM_W - 1);
	assign sts.root_last = step_q == STEP_W'(rpm_pkg::ROOT_STEPS - 1);
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;

endmodule
